/* sv/mmbs_pkg.sv */
package mmbs_pkg;

    // Widths sized for the largest supported pyramid (4096 texels, 12 levels).
    localparam int DIMX_W = 13;
    localparam int LVL_W  = 4;
    localparam int NUM_W  = 20;
    localparam int Q_DEPTH = 2;

    localparam logic [15:0] FULL_SCALE = 16'hFFFF;
    localparam logic [33:0] Q28_ONE    = 34'h010000000;

    // Request codes.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Pyramid shape shared by the front and back ends.
    typedef struct packed {
        logic [DIMX_W-1:0] width;
        logic [DIMX_W-1:0] height;
        logic [LVL_W-1:0]  nlev;
    } cfg_t;

    // One classified request waiting for the back end.
    typedef struct packed {
        logic               is_sample;
        logic               empty;
        logic               blend;
        logic [LVL_W-1:0]   lv_a;
        logic [LVL_W-1:0]   lv_b;
        logic [NUM_W-1:0]   num;
        logic [NUM_W-1:0]   den;
        logic signed [32:0] xq;
        logic signed [32:0] yq;
        logic [2:0]         wr_level;
        logic [15:0]        idx;
        logic [15:0]        value;
    } qitem_t;

endpackage

/* sv/mmbs_queue.sv */
module mmbs_queue
    import mmbs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qitem_t push_item,
    input  logic   pop,
    output logic   q_valid,
    output qitem_t q_item,
    output logic   q_full
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    qitem_t        entry_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CW'(Q_DEPTH));
    assign q_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/mmbs_front.sv */
module mmbs_front
    import mmbs_pkg::*;
#(
    parameter int MAX_DIM    = 256,
    parameter int MAX_LEVELS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               req_type,
    input  logic [2:0]         level,
    input  logic [15:0]        texel_index,
    input  logic [15:0]        texel_value,
    input  logic signed [15:0] x_pos,
    input  logic signed [15:0] y_pos,
    input  logic [15:0]        radius,
    input  logic signed [15:0] cos_angle,
    input  logic signed [15:0] sin_angle,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data,
    input  logic               q_full,
    output logic               busy,
    output logic               q_push,
    output qitem_t             q_item,
    output cfg_t               cfg
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [31:0]      cfg_clamped;
    logic [DIM_W-1:0] min_dim;
    logic [LVL_W-1:0] nlev;

    logic               s1_valid_reg;
    logic               s1_type_reg;
    logic [2:0]         s1_level_reg;
    logic [15:0]        s1_idx_reg;
    logic [15:0]        s1_value_reg;
    logic [15:0]        s1_radius_reg;
    logic signed [31:0] p_cx_reg, p_sy_reg, p_cy_reg, p_sx_reg;

    logic                  accept;
    logic [MAX_LEVELS-1:0] hit;
    logic [LVL_W-1:0]      sel;
    logic [DIM_W-1:0]      w_hi, w_lo;
    logic [31:0]           num32, den32;

    assign accept = start && !busy;
    assign busy   = s1_valid_reg || q_full;
    assign q_push = s1_valid_reg && !q_full;

    // Register writes clamp to the largest supported dimension.
    assign cfg_clamped = (32'(cfg_data) > 32'(MAX_DIM)) ? 32'(MAX_DIM) : 32'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_clamped[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_clamped[DIM_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // Level count is the highest set bit of the smaller dimension, capped at MAX_LEVELS.
    always_comb
    begin
        min_dim = (width_reg < height_reg) ? width_reg : height_reg;
        nlev    = '0;
        for (int k = 1; k < DIM_W; k++)
        begin
            if (min_dim[k])
            begin
                nlev = LVL_W'(k);
            end
        end
        if (32'(nlev) > 32'(MAX_LEVELS))
        begin
            nlev = LVL_W'(MAX_LEVELS);
        end
    end

    assign cfg.width  = DIMX_W'(width_reg);
    assign cfg.height = DIMX_W'(height_reg);
    assign cfg.nlev   = nlev;

    // Capture stage: rotation products are formed as the request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_type_reg   <= req_type;
            s1_level_reg  <= level;
            s1_idx_reg    <= texel_index;
            s1_value_reg  <= texel_value;
            s1_radius_reg <= radius;
            p_cx_reg      <= cos_angle * x_pos;
            p_sy_reg      <= sin_angle * y_pos;
            p_cy_reg      <= cos_angle * y_pos;
            p_sx_reg      <= sin_angle * x_pos;
        end
    end

    // Level selection: the first level narrower than the radius.
    always_comb
    begin
        for (int k = 0; k < MAX_LEVELS; k++)
        begin
            hit[k] = (32'(k) < 32'(nlev))
                  && ((32'(width_reg >> k) << 7) < 32'(s1_radius_reg));
        end
        sel = nlev;
        for (int k = MAX_LEVELS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                sel = LVL_W'(k);
            end
        end
        w_hi  = width_reg >> (sel - 1'b1);
        w_lo  = width_reg >> sel;
        num32 = (32'(w_hi) << 7) - 32'(s1_radius_reg);
        den32 = 32'(w_hi - w_lo) << 7;
    end

    // Classified request toward the back end.
    always_comb
    begin
        q_item.is_sample = (s1_type_reg == REQ_SAMPLE);
        q_item.empty     = (nlev == '0);
        q_item.blend     = (sel != nlev) && (sel != '0);
        q_item.lv_a      = (sel == '0) ? '0 : sel - 1'b1;
        q_item.lv_b      = sel;
        q_item.num       = num32[NUM_W-1:0];
        q_item.den       = den32[NUM_W-1:0];
        q_item.xq        = $signed({p_cx_reg[31], p_cx_reg}) + $signed({p_sy_reg[31], p_sy_reg});
        q_item.yq        = $signed({p_cy_reg[31], p_cy_reg}) - $signed({p_sx_reg[31], p_sx_reg});
        q_item.wr_level  = s1_level_reg;
        q_item.idx       = s1_idx_reg;
        q_item.value     = s1_value_reg;
    end

endmodule

/* sv/mmbs_back.sv */
module mmbs_back
    import mmbs_pkg::*;
#(
    parameter int MAX_DIM     = 256,
    parameter int STORE_DEPTH = 131072
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  qitem_t      q_item,
    output logic        q_pop,
    output logic        done,
    output logic [15:0] mask_value,
    output logic        used_default
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int LA_W  = 2 * DIM_W + 2;
    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int M_W   = 35 + DIM_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_BASE  = 5'd1;
    localparam logic [4:0] S_WRITE = 5'd2;
    localparam logic [4:0] S_MULX  = 5'd3;
    localparam logic [4:0] S_MULY  = 5'd4;
    localparam logic [4:0] S_CLSY  = 5'd5;
    localparam logic [4:0] S_ROW0  = 5'd6;
    localparam logic [4:0] S_ROW1  = 5'd7;
    localparam logic [4:0] S_READ  = 5'd8;
    localparam logic [4:0] S_TOP   = 5'd9;
    localparam logic [4:0] S_BOT   = 5'd10;
    localparam logic [4:0] S_ACC1  = 5'd11;
    localparam logic [4:0] S_ACC2  = 5'd12;
    localparam logic [4:0] S_LFIN  = 5'd13;
    localparam logic [4:0] S_DIV   = 5'd14;
    localparam logic [4:0] S_MIX1  = 5'd15;
    localparam logic [4:0] S_MIX2  = 5'd16;
    localparam logic [4:0] S_MFIN  = 5'd17;

    logic [4:0] state_reg;

    qitem_t             item_reg;
    logic [LVL_W-1:0]   cur_lv_reg;
    logic               second_reg;
    logic [LVL_W-1:0]   j_reg;
    logic [LA_W-1:0]    base_reg;
    logic [DIM_W-1:0]   w_reg, h_reg;
    logic signed [M_W-1:0] mx_reg, my_reg;
    logic [DIM_W-1:0]   cx_reg, cx1_reg, cy_reg, cy1_reg;
    logic [15:0]        fx_reg, fy_reg;
    logic [LA_W-1:0]    row0_reg, row1_reg;
    logic [2:0]         rd_cnt_reg;
    logic               bad_reg;
    logic [15:0]        tex_reg [4];
    logic [31:0]        top_reg, bot_reg;
    logic [48:0]        acc_reg;
    logic [15:0]        hi_reg, lo_reg;
    logic [NUM_W:0]     rem_reg;
    logic [15:0]        quo_reg;
    logic [4:0]         dcnt_reg;
    logic [32:0]        mix_reg;
    logic               done_reg;
    logic [15:0]        mask_reg;
    logic               dflt_reg;

    logic [15:0]        mem [STORE_DEPTH];
    logic [15:0]        mem_q;

    logic [DIM_W-1:0]   bw, bh;
    logic [LA_W-1:0]    rd_addr;
    logic [LA_W-1:0]    wr_addr;
    logic               wr_ok;
    logic               mem_we;
    logic [DIM_W-1:0]   cls_cell, cls_cell1;
    logic [15:0]        cls_frac;
    logic signed [M_W-1:0] cls_m;
    logic [DIM_W-1:0]   cls_dim;
    logic [48:0]        lsum;
    logic [15:0]        lres;
    logic [33:0]        msum;
    logic [15:0]        mres;
    logic [NUM_W:0]     rem2;
    logic signed [33:0] px, py;

    assign bw = cfg.width[DIM_W-1:0];
    assign bh = cfg.height[DIM_W-1:0];

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign done         = done_reg;
    assign mask_value   = mask_reg;
    assign used_default = dflt_reg;

    assign px = $signed({item_reg.xq[32], item_reg.xq}) + $signed(Q28_ONE);
    assign py = $signed({item_reg.yq[32], item_reg.yq}) + $signed(Q28_ONE);

    // Axis mapping: clamp the Q29 position to the level edges.
    always_comb
    begin
        cls_m   = (state_reg == S_MULY) ? mx_reg : my_reg;
        cls_dim = (state_reg == S_MULY) ? w_reg : h_reg;
        if (cls_m < 0)
        begin
            cls_cell = '0;
            cls_frac = '0;
        end
        else if (cls_m >= $signed({6'b0, cls_dim, 29'b0}))
        begin
            cls_cell = cls_dim - 1'b1;
            cls_frac = '0;
        end
        else
        begin
            cls_cell = cls_m[29 +: DIM_W];
            cls_frac = cls_m[28:13];
        end
        cls_cell1 = (32'(cls_cell) + 32'd1 < 32'(cls_dim)) ? cls_cell + 1'b1 : cls_cell;
    end

    // Texel address of the current read slot.
    always_comb
    begin
        unique case (rd_cnt_reg[1:0])
            2'd0:    rd_addr = row0_reg + LA_W'(cx_reg);
            2'd1:    rd_addr = row0_reg + LA_W'(cx1_reg);
            2'd2:    rd_addr = row1_reg + LA_W'(cx_reg);
            default: rd_addr = row1_reg + LA_W'(cx1_reg);
        endcase
    end

    // Texel write legality.
    assign wr_addr = base_reg + LA_W'(item_reg.idx);
    assign wr_ok   = (cur_lv_reg < cfg.nlev)
                  && (32'(item_reg.idx) < (32'(w_reg) * 32'(h_reg)))
                  && (32'(wr_addr) < 32'(STORE_DEPTH));
    assign mem_we  = (state_reg == S_WRITE) && wr_ok;

    // Rounding of the bilinear sum and of the blend.
    always_comb
    begin
        lsum = acc_reg + 49'h0_0000_8000_0000;
        lres = (lsum[48:32] > 17'(FULL_SCALE)) ? FULL_SCALE : lsum[47:32];
        msum = 34'(mix_reg) + 34'd32768;
        mres = (msum[33:16] > 18'(FULL_SCALE)) ? FULL_SCALE : msum[31:16];
        rem2 = rem_reg << 1;
    end

    // Texel store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr[AW-1:0]] <= item_reg.value;
        end
        mem_q <= mem[rd_addr[AW-1:0]];
    end

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.is_sample && q_item.empty)
                        begin
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_BASE;
                        end
                    end
                end
                S_BASE:
                begin
                    if (j_reg >= cur_lv_reg)
                    begin
                        state_reg <= item_reg.is_sample ? S_MULX : S_WRITE;
                    end
                end
                S_WRITE: state_reg <= S_IDLE;
                S_MULX:  state_reg <= S_MULY;
                S_MULY:  state_reg <= S_CLSY;
                S_CLSY:  state_reg <= S_ROW0;
                S_ROW0:  state_reg <= S_ROW1;
                S_ROW1:  state_reg <= S_READ;
                S_READ:
                begin
                    if (rd_cnt_reg == 3'd4)
                    begin
                        state_reg <= S_TOP;
                    end
                end
                S_TOP:
                begin
                    if (bad_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_BOT;
                    end
                end
                S_BOT:   state_reg <= S_ACC1;
                S_ACC1:  state_reg <= S_ACC2;
                S_ACC2:  state_reg <= S_LFIN;
                S_LFIN:
                begin
                    if (!item_reg.blend)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (!second_reg)
                    begin
                        state_reg <= S_BASE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (dcnt_reg == 5'd15)
                    begin
                        state_reg <= S_MIX1;
                    end
                end
                S_MIX1:  state_reg <= S_MIX2;
                S_MIX2:  state_reg <= S_MFIN;
                S_MFIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                item_reg   <= q_item;
                cur_lv_reg <= q_item.is_sample ? q_item.lv_a : LVL_W'(q_item.wr_level);
                second_reg <= 1'b0;
                j_reg      <= '0;
                base_reg   <= '0;
                mask_reg   <= FULL_SCALE;
                dflt_reg   <= 1'b1;
            end
            S_BASE:
            begin
                if (j_reg < cur_lv_reg)
                begin
                    base_reg <= base_reg + LA_W'(bw >> j_reg) * LA_W'(bh >> j_reg);
                    j_reg    <= j_reg + 1'b1;
                end
                w_reg <= bw >> cur_lv_reg;
                h_reg <= bh >> cur_lv_reg;
            end
            S_MULX:
            begin
                mx_reg <= px * $signed({1'b0, w_reg});
            end
            S_MULY:
            begin
                my_reg  <= py * $signed({1'b0, h_reg});
                cx_reg  <= cls_cell;
                cx1_reg <= cls_cell1;
                fx_reg  <= cls_frac;
            end
            S_CLSY:
            begin
                cy_reg  <= cls_cell;
                cy1_reg <= cls_cell1;
                fy_reg  <= cls_frac;
            end
            S_ROW0:
            begin
                row0_reg <= base_reg + LA_W'(cy_reg) * LA_W'(w_reg);
            end
            S_ROW1:
            begin
                row1_reg   <= base_reg + LA_W'(cy1_reg) * LA_W'(w_reg);
                rd_cnt_reg <= '0;
                bad_reg    <= 1'b0;
            end
            S_READ:
            begin
                if (rd_cnt_reg != 3'd4)
                begin
                    if (32'(rd_addr) >= 32'(STORE_DEPTH))
                    begin
                        bad_reg <= 1'b1;
                    end
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (rd_cnt_reg != 3'd0)
                begin
                    tex_reg[rd_cnt_reg[1:0] - 2'd1] <= mem_q;
                end
            end
            S_TOP:
            begin
                top_reg <= tex_reg[0] * (17'h10000 - 17'(fx_reg)) + tex_reg[1] * fx_reg;
            end
            S_BOT:
            begin
                bot_reg <= tex_reg[2] * (17'h10000 - 17'(fx_reg)) + tex_reg[3] * fx_reg;
            end
            S_ACC1:
            begin
                acc_reg <= top_reg * (17'h10000 - 17'(fy_reg));
            end
            S_ACC2:
            begin
                acc_reg <= acc_reg + bot_reg * fy_reg;
            end
            S_LFIN:
            begin
                if (!item_reg.blend)
                begin
                    mask_reg <= lres;
                    dflt_reg <= 1'b0;
                end
                else if (!second_reg)
                begin
                    hi_reg     <= lres;
                    second_reg <= 1'b1;
                    cur_lv_reg <= item_reg.lv_b;
                    j_reg      <= '0;
                    base_reg   <= '0;
                end
                else
                begin
                    lo_reg   <= lres;
                    rem_reg  <= {1'b0, item_reg.num};
                    quo_reg  <= '0;
                    dcnt_reg <= '0;
                end
            end
            S_DIV:
            begin
                // One quotient bit per cycle, restoring form.
                if (rem2 >= {1'b0, item_reg.den})
                begin
                    rem_reg <= rem2 - {1'b0, item_reg.den};
                    quo_reg <= {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2;
                    quo_reg <= {quo_reg[14:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            S_MIX1:
            begin
                mix_reg <= hi_reg * (17'h10000 - 17'(quo_reg));
            end
            S_MIX2:
            begin
                mix_reg <= mix_reg + lo_reg * quo_reg;
            end
            S_MFIN:
            begin
                mask_reg <= mres;
                dflt_reg <= 1'b0;
            end
            default:
            begin
                j_reg <= j_reg;
            end
        endcase
    end

endmodule

/* sv/mip_mask_bilinear_sampler.sv */
// Flow: a texel write passes the capture register, the queue and the back end's level walk
// before it lands in the store; a sample on one level L is filtered once, a blended sample
// on L and L + 1 is filtered on both levels and mixed by a bit-serial weight division,
// and a sample of an empty pyramid strobes its default result straight from idle.
// Flow control: the front end takes no new request while it still holds one, the back end
// runs one at a time behind a two-entry queue; the receiver cannot stall. Reset clears
// control state and the shape registers; the texel store is not cleared.
module mip_mask_bilinear_sampler
    import mmbs_pkg::*;
#(
    parameter int MAX_DIM     = 256,
    parameter int MAX_LEVELS  = 8,
    parameter int STORE_DEPTH = 131072
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [2:0]         level,
    input  logic [15:0]        texel_index,
    input  logic [15:0]        texel_value,
    input  logic signed [15:0] x_pos,
    input  logic signed [15:0] y_pos,
    input  logic [15:0]        radius,
    input  logic signed [15:0] cos_angle,
    input  logic signed [15:0] sin_angle,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data,
    output logic               done,
    output logic [15:0]        mask_value,
    output logic               used_default
);

    cfg_t   cfg;
    logic   q_push, q_pop, q_valid, q_full;
    qitem_t push_item, q_item;

    // Front end: capture, rotation and level selection.
    mmbs_front #(
        .MAX_DIM    (MAX_DIM),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req_type    (req_type),
        .level       (level),
        .texel_index (texel_index),
        .texel_value (texel_value),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .radius      (radius),
        .cos_angle   (cos_angle),
        .sin_angle   (sin_angle),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .busy        (busy),
        .q_push      (q_push),
        .q_item      (push_item),
        .cfg         (cfg)
    );

    // Request queue between the two ends.
    mmbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_full    (q_full)
    );

    // Back end: texel store and sampling sequencer.
    mmbs_back #(
        .MAX_DIM     (MAX_DIM),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .done         (done),
        .mask_value   (mask_value),
        .used_default (used_default)
    );

endmodule

/* sv/mmbs_checker.sv */
module mmbs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [15:0] mask_value,
    input logic        used_default
);

    // A result never carries unknown bits.
    a_done_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({mask_value, used_default}))
        else $error("result carries unknown bits");

    // A default result always carries full scale.
    a_default_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && used_default) |-> (mask_value == 16'hFFFF))
        else $error("default result not full scale");

    // An accepted request holds off the next one by raising busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // No result right out of reset.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !done)
        else $error("result strobe at reset release");

endmodule

bind mip_mask_bilinear_sampler mmbs_checker u_mmbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .mask_value   (mask_value),
    .used_default (used_default)
);
